[sv/cgb_pkg.sv]
package cgb_pkg;

   // pixel and register formats
   localparam int PIX_W            = 8;
   localparam int CFG_FRAC_BITS    = 12;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;
   localparam int GAIN_W           = 16;
   localparam int OFFSET_W         = 14;
   localparam int GAMMA_W          = 16;

   // internal fraction bits of x^g
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_MAX     = 24;

   // root chain runs in Q.30
   localparam int ROOT_FRAC_BITS = 30;
   localparam int ROOT_W         = ROOT_FRAC_BITS;
   localparam int CHAIN_W        = ROOT_FRAC_BITS + 1;
   localparam int SHIFT_WORD_W   = 32;
   localparam int MAX_EXP_INT    = 40;

   localparam int LOG_ROM_W   = FRAC_BITS_MAX + 4;
   localparam int LOG_ROM_LEN = 1 << PIX_W;

   // pipeline depth of the scale lane (map, x255, scale, divider)
   localparam int SCALE_LAT = 12;
   localparam int QUOT_BITS = PIX_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONTRAST   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THREE      = 3'd4;

   // reset values
   localparam logic [GAIN_W-1:0]   CONTRAST_RESET   = 16'd4096;
   localparam logic [OFFSET_W-1:0] BRIGHTNESS_RESET = 14'd0;
   localparam logic [GAMMA_W-1:0]  GAMMA_RESET      = 16'd4096;
   localparam logic                LUMA_RESET       = 1'b0;
   localparam logic                THREE_RESET      = 1'b1;

   typedef struct packed {
      logic [GAIN_W-1:0]   contrast;
      logic [OFFSET_W-1:0] brightness;
      logic [GAMMA_W-1:0]  gamma;
      logic                luma;
      logic                three;
   } cgb_cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } cgb_pix_type;

   typedef logic [LOG_ROM_W-1:0] log_rom_type [LOG_ROM_LEN];
   typedef logic [ROOT_W-1:0]    root_rom_type [FRAC_BITS_MAX+1];

   function automatic int pow_latency(input int frac_bits);
      return frac_bits + 3;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int s = 31; s >= 0; s--) begin
         t = r | (64'(1) << s);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // log2(255/b) in Q.frac_bits, exact bit-serial squaring
   function automatic log_rom_type build_log_rom(input int frac_bits);
      log_rom_type rom;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] frac;
      int k;
      rom[0] = '0;
      for (int b = 1; b < LOG_ROM_LEN; b++) begin
         num = 64'(255) << ROOT_FRAC_BITS;
         rem = '0;
         y   = '0;
         for (int i = 37; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            y   = y << 1;
            if (rem >= 64'(b)) begin
               rem  = rem - 64'(b);
               y[0] = 1'b1;
            end
         end
         k = 0;
         for (int j = 0; j < 8; j++) begin
            if ((y >> k) >= (64'(2) << ROOT_FRAC_BITS)) k++;
         end
         z    = y >> k;
         frac = '0;
         for (int i = 0; i <= frac_bits; i++) begin
            z    = (z * z) >> ROOT_FRAC_BITS;
            frac = frac << 1;
            if (z >= (64'(2) << ROOT_FRAC_BITS)) begin
               frac = frac | 64'(1);
               z    = z >> 1;
            end
         end
         rom[b] = LOG_ROM_W'((64'(k) << frac_bits) + ((frac + 64'(1)) >> 1));
      end
      return rom;
   endfunction

   // 2^(-2^-i) in Q.30, entry 0 is one half
   function automatic root_rom_type build_root_rom(input int frac_bits);
      root_rom_type rom;
      for (int i = 0; i <= FRAC_BITS_MAX; i++) begin
         if (i == 0) begin
            rom[i] = ROOT_W'(64'(1) << (ROOT_FRAC_BITS - 1));
         end else if (i <= frac_bits) begin
            rom[i] = ROOT_W'(isqrt64(64'(rom[i-1]) << ROOT_FRAC_BITS));
         end else begin
            rom[i] = '0;
         end
      end
      return rom;
   endfunction

endpackage

[sv/cgb_stream_if.sv]
interface cgb_req_if;
   logic                        valid;
   logic                        ready;
   logic [cgb_pkg::PIX_W-1:0]   blue_in;
   logic [cgb_pkg::PIX_W-1:0]   green_in;
   logic [cgb_pkg::PIX_W-1:0]   red_in;

   modport source (output valid, output blue_in, output green_in, output red_in,
                   input ready);
   modport sink   (input valid, input blue_in, input green_in, input red_in,
                   output ready);
endinterface

interface cgb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cgb_pkg::PIX_W-1:0]   blue_out;
   logic [cgb_pkg::PIX_W-1:0]   green_out;
   logic [cgb_pkg::PIX_W-1:0]   red_out;

   modport source (output valid, output blue_out, output green_out, output red_out,
                   input ready);
   modport sink   (input valid, input blue_out, input green_out, input red_out,
                   output ready);
endinterface

[sv/gamma_contrast_brightness_pixel_unit.sv]
// Gamma, contrast and brightness correction of B,G,R (or gray) pixels.
// Each byte b is mapped to contrast*(b/255)^gamma + brightness, scaled back to a
// byte with round-to-nearest and saturation; in luma mode on color pixels only
// V = max(B,G,R) is mapped and each channel is scaled by newV/V. x^gamma is
// exp2(gamma*log2 x) from a 256-entry log ROM and a chain of square-root
// factors. Throughput is one pixel per clock while rsp does not stall. The
// root chain costs one multiplier stage per fraction bit, the scaling
// divider nine stages. When rsp stalls, one transfer lands in a skid
// register and req.ready drops the next cycle.
// Configuration registers are written through csr_we/csr_idx/csr_wdata and
// must only change while no pixel is in flight.
module gamma_contrast_brightness_pixel_unit #(
   parameter int INTERNAL_FRAC_BITS = cgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   cgb_req_if.sink                           req,
   cgb_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [cgb_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [cgb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PXW      = cgb_pkg::PIX_W;
   localparam int PIPE_LAT = 1 + cgb_pkg::pow_latency(INTERNAL_FRAC_BITS)
                             + cgb_pkg::SCALE_LAT;
   localparam int LANES    = 3;

   // ---------------------------------------------------------------- config
   cgb_pkg::cgb_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            cgb_pkg::CSR_CONTRAST:   cfg_in.contrast   = csr_wdata[cgb_pkg::GAIN_W-1:0];
            cgb_pkg::CSR_BRIGHTNESS: cfg_in.brightness = csr_wdata[cgb_pkg::OFFSET_W-1:0];
            cgb_pkg::CSR_GAMMA:      cfg_in.gamma      = csr_wdata[cgb_pkg::GAMMA_W-1:0];
            cgb_pkg::CSR_LUMA:       cfg_in.luma       = csr_wdata[0];
            cgb_pkg::CSR_THREE:      cfg_in.three      = csr_wdata[0];
            default:                 cfg_in            = cfg_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contrast   <= cgb_pkg::CONTRAST_RESET;
         cfg_ff.brightness <= cgb_pkg::BRIGHTNESS_RESET;
         cfg_ff.gamma      <= cgb_pkg::GAMMA_RESET;
         cfg_ff.luma       <= cgb_pkg::LUMA_RESET;
         cfg_ff.three      <= cgb_pkg::THREE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------- pipe control
   // whole pipe advances unless the skid register is holding a result
   logic                 en;
   logic                 skid_valid_ff, skid_valid_in;
   logic [PIPE_LAT-1:0]  vld_ff, vld_in;

   assign en        = !skid_valid_ff;
   assign req.ready = en;

   always_comb begin
      vld_in = {vld_ff[PIPE_LAT-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------- input stage
   cgb_pkg::cgb_pix_type pix_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff.blue  <= req.blue_in;
         pix_ff.green <= req.green_in;
         pix_ff.red   <= req.red_in;
      end
   end

   // V and per-lane byte selection
   logic [PXW-1:0] peak;
   logic [PXW-1:0] chan  [LANES];
   logic [PXW-1:0] lbyte [LANES];
   logic           luma_eff;

   always_comb begin
      peak = pix_ff.blue;
      if (pix_ff.green > peak) peak = pix_ff.green;
      if (pix_ff.red > peak)   peak = pix_ff.red;
      luma_eff = cfg_ff.luma && cfg_ff.three;
      chan[0]  = pix_ff.blue;
      chan[1]  = pix_ff.green;
      chan[2]  = pix_ff.red;
      for (int l = 0; l < LANES; l++) begin
         lbyte[l] = luma_eff ? peak : chan[l];
      end
   end

   // ---------------------------------------------------------- lanes
   logic [PXW-1:0] fin [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [INTERNAL_FRAC_BITS:0] p;
      logic [PXW-1:0]              pchan;
      logic [PXW-1:0]              ppeak;

      cgb_pow #(
         .FRAC_BITS (INTERNAL_FRAC_BITS)
      ) u_pow (
         .clock    (clock),
         .en       (en),
         .gamma    (cfg_ff.gamma),
         .byte_in  (lbyte[l]),
         .chan_in  (chan[l]),
         .peak_in  (peak),
         .p_out    (p),
         .chan_out (pchan),
         .peak_out (ppeak)
      );

      cgb_scale #(
         .FRAC_BITS (INTERNAL_FRAC_BITS)
      ) u_scale (
         .clock    (clock),
         .en       (en),
         .cfg      (cfg_ff),
         .p_in     (p),
         .chan_in  (pchan),
         .peak_in  (ppeak),
         .byte_out (fin[l])
      );
   end

   // gray format drives only blue
   cgb_pkg::cgb_pix_type fin_pix;

   always_comb begin
      fin_pix.blue  = fin[0];
      fin_pix.green = cfg_ff.three ? fin[1] : '0;
      fin_pix.red   = cfg_ff.three ? fin[2] : '0;
   end

   // ---------------------------------------------------------- output + skid
   logic                 out_valid_ff, out_valid_in;
   cgb_pkg::cgb_pix_type out_ff, out_in;
   cgb_pkg::cgb_pix_type skid_ff, skid_in;
   logic                 push;
   logic                 out_xfer;

   always_comb begin
      push          = en && vld_ff[PIPE_LAT-1];
      out_xfer      = out_valid_ff && rsp.ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_xfer || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in       = fin_pix;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = fin_pix;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.blue_out  = out_ff.blue;
   assign rsp.green_out = out_ff.green;
   assign rsp.red_out   = out_ff.red;

   // ---------------------------------------------------------- assertions
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp.ready))
      else $error("skid filled without a stalled output");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipe valid bits moved during stall");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp.ready) |=> (skid_valid_ff && out_valid_ff))
      else $error("held result lost while output stalled");

endmodule

[sv/cgb_pow.sv]
// x^gamma for one byte: log ROM, gamma multiply, root product chain, final shift
module cgb_pow #(
   parameter int FRAC_BITS = cgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [cgb_pkg::GAMMA_W-1:0]         gamma,
   input  logic [cgb_pkg::PIX_W-1:0]           byte_in,
   input  logic [cgb_pkg::PIX_W-1:0]           chan_in,
   input  logic [cgb_pkg::PIX_W-1:0]           peak_in,
   output logic [FRAC_BITS:0]                  p_out,
   output logic [cgb_pkg::PIX_W-1:0]           chan_out,
   output logic [cgb_pkg::PIX_W-1:0]           peak_out
);

   localparam int LW  = FRAC_BITS + 4;
   localparam int SW  = LW + cgb_pkg::GAMMA_W + 1;
   localparam int TW  = SW - cgb_pkg::CFG_FRAC_BITS;
   localparam int NW  = TW - FRAC_BITS;
   localparam int CW  = cgb_pkg::CHAIN_W;
   localparam int PW  = CW + cgb_pkg::ROOT_W;
   localparam int RF  = cgb_pkg::ROOT_FRAC_BITS;
   localparam int XW  = cgb_pkg::SHIFT_WORD_W;
   localparam int XSW = $clog2(XW);

   localparam cgb_pkg::log_rom_type  LOG_ROM  = cgb_pkg::build_log_rom(FRAC_BITS);
   localparam cgb_pkg::root_rom_type ROOT_ROM = cgb_pkg::build_root_rom(FRAC_BITS);

   // stage a: log lookup
   logic [LW-1:0]                 log_ff, log_in;
   logic                          zero_a_ff, zero_a_in;
   logic [cgb_pkg::PIX_W-1:0]     chan_a_ff, peak_a_ff;

   always_comb begin
      log_in    = LOG_ROM[byte_in][LW-1:0];
      zero_a_in = (byte_in == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         log_ff    <= log_in;
         zero_a_ff <= zero_a_in;
         chan_a_ff <= chan_in;
         peak_a_ff <= peak_in;
      end
   end

   // stage b (index 0) and root chain stages 1..FRAC_BITS
   logic [CW-1:0]             pch_ff  [0:FRAC_BITS];
   logic [CW-1:0]             pch_in  [0:FRAC_BITS];
   logic [NW-1:0]             n_ff    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0]      f_ff    [0:FRAC_BITS];
   logic                      zero_ff [0:FRAC_BITS];
   logic [cgb_pkg::PIX_W-1:0] chan_ff [0:FRAC_BITS];
   logic [cgb_pkg::PIX_W-1:0] peak_ff [0:FRAC_BITS];
   logic [SW-1:0]             tsum;
   logic [TW-1:0]             tval;

   always_comb begin
      tsum      = SW'(gamma) * SW'(log_ff) + (SW'(1) << (cgb_pkg::CFG_FRAC_BITS - 1));
      tval      = tsum[SW-1:cgb_pkg::CFG_FRAC_BITS];
      pch_in[0] = CW'(1) << RF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pch_ff[0]  <= pch_in[0];
         n_ff[0]    <= tval[TW-1:FRAC_BITS];
         f_ff[0]    <= tval[FRAC_BITS-1:0];
         zero_ff[0] <= zero_a_ff;
         chan_ff[0] <= chan_a_ff;
         peak_ff[0] <= peak_a_ff;
      end
   end

   // one root multiply per stage, for fraction bit FRAC_BITS-i
   for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_chain
      logic [PW-1:0] prod;
      always_comb begin
         prod      = PW'(pch_ff[i-1]) * PW'(ROOT_ROM[i]) + (PW'(1) << (RF - 1));
         pch_in[i] = f_ff[i-1][FRAC_BITS-i] ? prod[PW-1:RF] : pch_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            pch_ff[i]  <= pch_in[i];
            n_ff[i]    <= n_ff[i-1];
            f_ff[i]    <= f_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
            chan_ff[i] <= chan_ff[i-1];
            peak_ff[i] <= peak_ff[i-1];
         end
      end
   end

   // stage d: shift by integer part of exponent, round to nearest
   logic [FRAC_BITS:0]        p_ff, p_in;
   logic [cgb_pkg::PIX_W-1:0] chan_d_ff, peak_d_ff;
   logic [NW:0]               sh;
   logic [XW-1:0]             rsum;
   logic [XW-1:0]             rshift;
   logic                      vanish;

   always_comb begin
      sh     = (NW+1)'(RF - FRAC_BITS) + (NW+1)'(n_ff[FRAC_BITS]);
      vanish = (n_ff[FRAC_BITS] > NW'(cgb_pkg::MAX_EXP_INT)) || (sh > (NW+1)'(XW - 1));
      rsum   = XW'(pch_ff[FRAC_BITS]) + (XW'(1) << (sh[XSW-1:0] - XSW'(1)));
      rshift = rsum >> sh[XSW-1:0];
      if (gamma == '0) begin
         p_in = (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else if (zero_ff[FRAC_BITS] || vanish) begin
         p_in = '0;
      end else begin
         p_in = rshift[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= p_in;
         chan_d_ff <= chan_ff[FRAC_BITS];
         peak_d_ff <= peak_ff[FRAC_BITS];
      end
   end

   assign p_out    = p_ff;
   assign chan_out = chan_d_ff;
   assign peak_out = peak_d_ff;

endmodule

[sv/cgb_scale.sv]
// contrast/brightness map, byte conversion and newV/V scaling divider
module cgb_scale #(
   parameter int FRAC_BITS = cgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         en,
   input  cgb_pkg::cgb_cfg_type         cfg,
   input  logic [FRAC_BITS:0]           p_in,
   input  logic [cgb_pkg::PIX_W-1:0]    chan_in,
   input  logic [cgb_pkg::PIX_W-1:0]    peak_in,
   output logic [cgb_pkg::PIX_W-1:0]    byte_out
);

   localparam int PXW  = cgb_pkg::PIX_W;
   localparam int CPW  = FRAC_BITS + 1 + cgb_pkg::GAIN_W;
   localparam int YW   = FRAC_BITS + 18;
   localparam int Y2W  = YW - 1 + PXW;
   localparam int NUMW = Y2W + PXW + 1;
   localparam int QSH  = FRAC_BITS + cgb_pkg::CFG_FRAC_BITS;
   localparam int QB   = cgb_pkg::QUOT_BITS;
   localparam logic [PXW-1:0] BYTE_MAX = '1;

   // s1: y = contrast*p + brightness
   logic signed [YW-1:0] y_ff, y_in;
   logic [CPW-1:0]       cp;
   logic signed [YW-1:0] bofs;
   logic [PXW-1:0]       chan1_ff, peak1_ff;

   always_comb begin
      cp   = CPW'(cfg.contrast) * CPW'(p_in);
      bofs = YW'($signed(cfg.brightness));
      y_in = $signed(YW'(cp)) + (bofs <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff     <= y_in;
         chan1_ff <= chan_in;
         peak1_ff <= peak_in;
      end
   end

   // s2: 255*y for non-negative y
   logic [Y2W-1:0] y2_ff, y2_in;
   logic           neg2_ff, neg2_in;
   logic [PXW-1:0] chan2_ff, peak2_ff;

   always_comb begin
      neg2_in = y_ff[YW-1];
      y2_in   = (Y2W'(y_ff[YW-2:0]) << PXW) - Y2W'(y_ff[YW-2:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y2_ff    <= y2_in;
         neg2_ff  <= neg2_in;
         chan2_ff <= chan1_ff;
         peak2_ff <= peak1_ff;
      end
   end

   // s3: plain byte, and numerator for the channel scaling
   logic [Y2W:0]    rsum;
   logic [Y2W-QSH:0] qwide;
   logic [PXW-1:0]  tb3_in, tb3_ff;
   logic [NUMW-1:0] num_in, num_ff;
   logic            neg3_ff;
   logic [PXW-1:0]  peak3_ff;

   always_comb begin
      rsum  = (Y2W+1)'(y2_ff) + ((Y2W+1)'(1) << (QSH - 1));
      qwide = rsum[Y2W:QSH];
      if (neg2_ff) begin
         tb3_in = '0;
      end else if (qwide > (Y2W-QSH+1)'(BYTE_MAX)) begin
         tb3_in = BYTE_MAX;
      end else begin
         tb3_in = qwide[PXW-1:0];
      end
      num_in = NUMW'(y2_ff) * NUMW'(chan2_ff) + (NUMW'(peak2_ff) << (QSH - 1));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tb3_ff   <= tb3_in;
         num_ff   <= num_in;
         neg3_ff  <= neg2_ff;
         peak3_ff <= peak2_ff;
      end
   end

   // divider: index 0 checks saturation, then one quotient bit per stage
   logic [NUMW-1:0] rem_ff [0:QB];
   logic [NUMW-1:0] rem_in [0:QB];
   logic [QB-1:0]   q_ff   [0:QB];
   logic [QB-1:0]   q_in   [0:QB];
   logic            sat_ff [0:QB];
   logic            sat_in0;
   logic [PXW-1:0]  tb_ff  [0:QB];
   logic            neg_ff [0:QB];
   logic [PXW-1:0]  peak_ff[0:QB];

   always_comb begin
      sat_in0   = num_ff >= (NUMW'(peak3_ff) << (QSH + QB));
      rem_in[0] = num_ff;
      q_in[0]   = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         sat_ff[0]  <= sat_in0;
         tb_ff[0]   <= tb3_ff;
         neg_ff[0]  <= neg3_ff;
         peak_ff[0] <= peak3_ff;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_div
      logic [NUMW-1:0] dsh;
      always_comb begin
         dsh       = NUMW'(peak_ff[k-1]) << (QSH + QB - k);
         rem_in[k] = rem_ff[k-1];
         q_in[k]   = q_ff[k-1];
         if (rem_ff[k-1] >= dsh) begin
            rem_in[k]       = rem_ff[k-1] - dsh;
            q_in[k][QB - k] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            sat_ff[k]  <= sat_ff[k-1];
            tb_ff[k]   <= tb_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            peak_ff[k] <= peak_ff[k-1];
         end
      end
   end

   // scaled path only for color pixels in luma mode with a nonzero peak
   logic use_div;

   always_comb begin
      use_div = cfg.luma && cfg.three && (peak_ff[QB] != '0);
      if (!use_div) begin
         byte_out = tb_ff[QB];
      end else if (neg_ff[QB]) begin
         byte_out = '0;
      end else if (sat_ff[QB]) begin
         byte_out = BYTE_MAX;
      end else begin
         byte_out = q_ff[QB];
      end
   end

endmodule
